// ===== rtl/core/nearest_palette_slot_defines.svh =====
// Assertion macros shared by the nearest palette slot RTL files.
`ifndef NEAREST_PALETTE_SLOT_DEFINES_SVH
`define NEAREST_PALETTE_SLOT_DEFINES_SVH
`ifndef SYNTHESIS
`define NPS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NPS_ASSERT_IMPLY(label, ante, cons, msg)
`define NPS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/nps_pkg.sv =====
// Shared constants, types and helper functions of the nearest palette slot block.
`default_nettype none
package nps_pkg;
   localparam int NUM_SLOTS  = 8;
   localparam int MAX_SLOTS  = 8;
   localparam int IDX_W      = 3;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int COLOR_W    = NUM_CH * CH_W;
   localparam int NUM_WORDS  = 4;
   localparam int WORD_W     = 2 * COLOR_W;
   localparam int CSR_IDX_W  = 3;
   localparam int SQ_W       = 2 * CH_W;
   localparam int DIST_W     = SQ_W + 2;
   localparam int GREEN_CH   = 1;
   localparam int BLUE_CH    = 0;

   localparam logic [DIST_W-1:0] DIST_FAR   = '1;
   localparam logic [CH_W-1:0]   GREEN_WARM = 8'd238;
   localparam logic [CH_W-1:0]   BLUE_WARM  = 8'd197;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PALETTE_0_1 = 3'd0,
      CSR_PALETTE_2_3 = 3'd1,
      CSR_PALETTE_4_5 = 3'd2,
      CSR_PALETTE_6_7 = 3'd3,
      CSR_NIGHT_MODE  = 3'd4
   } csr_index_type;

   typedef logic [CH_W-1:0] chan_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] distance;
   } cand_type;

   function automatic chan_type warm_channel(input chan_type c, input chan_type k);
      logic [SQ_W-1:0] p;
      p = c * k;
      return p[SQ_W-1:CH_W];
   endfunction

   function automatic chan_type abs_diff(input chan_type a, input chan_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // The left candidate always has the lower slot index, so it keeps ties.
   function automatic cand_type pick_nearer(input cand_type a, input cand_type b);
      return (b.distance < a.distance) ? b : a;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/nearest_palette_slot.sv =====
// Top level of the nearest palette slot block: registers, distance pipeline and output.
// An accepted color passes the query, diff, candidate and tree registers to rsp_slot_index.
// Throughput: one color per cycle; the pipeline has no feedback and the receiver cannot stall.
// A palette or night mode write is seen by colors accepted from the next cycle on.
// Reset is synchronous; it clears the palette words, night mode and all valid bits.
// busy is high only while reset is asserted.
`default_nettype none
`include "nearest_palette_slot_defines.svh"
module nearest_palette_slot (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [nps_pkg::COLOR_W-1:0]   req_query_color,
   output logic                          rsp_valid,
   output logic [nps_pkg::IDX_W-1:0]     rsp_slot_index,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nps_pkg::WORD_W-1:0]    csr_wdata
);
   localparam int MS = nps_pkg::MAX_SLOTS;
   localparam int NC = nps_pkg::NUM_CH;
   localparam int CW = nps_pkg::CH_W;

   logic                  accept;
   nps_pkg::word_type     pal_word_ff [nps_pkg::NUM_WORDS];
   nps_pkg::word_type     pal_word_in [nps_pkg::NUM_WORDS];
   logic                  night_ff, night_in;
   nps_pkg::color_type    slot_raw [MS];
   nps_pkg::color_type    slot_eff_ff [MS];
   nps_pkg::color_type    slot_eff_in [MS];
   logic                  q_valid_ff, q_valid_in;
   nps_pkg::color_type    q_color_ff, q_color_in;
   logic                  d_valid_ff, d_valid_in;
   nps_pkg::chan_type     diff_ff [MS][NC];
   nps_pkg::chan_type     diff_in [MS][NC];
   logic                  c_valid_ff, c_valid_in;
   nps_pkg::cand_type     cand_ff [MS];
   nps_pkg::cand_type     cand_in [MS];

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      pal_word_in = pal_word_ff;
      night_in    = night_ff;
      if (csr_valid) begin
         case (csr_index)
            nps_pkg::CSR_PALETTE_0_1: pal_word_in[0] = csr_wdata;
            nps_pkg::CSR_PALETTE_2_3: pal_word_in[1] = csr_wdata;
            nps_pkg::CSR_PALETTE_4_5: pal_word_in[2] = csr_wdata;
            nps_pkg::CSR_PALETTE_6_7: pal_word_in[3] = csr_wdata;
            nps_pkg::CSR_NIGHT_MODE:  night_in       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < nps_pkg::NUM_WORDS; w++) begin
            pal_word_ff[w] <= '0;
         end
         night_ff <= 1'b0;
      end else begin
         pal_word_ff <= pal_word_in;
         night_ff    <= night_in;
      end
   end

   for (genvar s = 0; s < MS; s++) begin : g_slot
      localparam int WI = s / 2;
      localparam int LO = (s % 2) * nps_pkg::COLOR_W;
      assign slot_raw[s] = pal_word_ff[WI][LO +: nps_pkg::COLOR_W];
   end

   always_comb begin
      for (int s = 0; s < MS; s++) begin
         slot_eff_in[s] = slot_raw[s];
         if (night_ff) begin
            slot_eff_in[s][nps_pkg::GREEN_CH*CW +: CW] = nps_pkg::warm_channel(
               slot_raw[s][nps_pkg::GREEN_CH*CW +: CW], nps_pkg::GREEN_WARM);
            slot_eff_in[s][nps_pkg::BLUE_CH*CW +: CW] = nps_pkg::warm_channel(
               slot_raw[s][nps_pkg::BLUE_CH*CW +: CW], nps_pkg::BLUE_WARM);
         end
      end
   end

   always_comb begin
      logic [nps_pkg::SQ_W-1:0]   sq;
      logic [nps_pkg::DIST_W-1:0] sum;
      q_valid_in = accept;
      q_color_in = req_query_color;
      d_valid_in = q_valid_ff;
      c_valid_in = d_valid_ff;
      for (int s = 0; s < MS; s++) begin
         for (int c = 0; c < NC; c++) begin
            diff_in[s][c] = nps_pkg::abs_diff(q_color_ff[c*CW +: CW], slot_eff_ff[s][c*CW +: CW]);
         end
      end
      for (int s = 0; s < MS; s++) begin
         sum = '0;
         for (int c = 0; c < NC; c++) begin
            sq  = diff_ff[s][c] * diff_ff[s][c];
            sum = sum + nps_pkg::DIST_W'(sq);
         end
         cand_in[s].idx      = nps_pkg::IDX_W'(s);
         cand_in[s].distance = (s < nps_pkg::NUM_SLOTS) ? sum : nps_pkg::DIST_FAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
         d_valid_ff <= d_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_eff_ff <= slot_eff_in;
      q_color_ff  <= q_color_in;
      diff_ff     <= diff_in;
      cand_ff     <= cand_in;
   end

   nps_min_tree u_min_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_cand   (cand_ff),
      .out_valid (rsp_valid),
      .out_idx   (rsp_slot_index)
   );

   `NPS_ASSERT_IMPLY(a_rsp_follows_req, start && !busy, ##6 rsp_valid, "accepted beat gave no result")
   `NPS_ASSERT_IMPLY(a_rsp_has_req, rsp_valid, $past(start && !busy, 6), "result without accepted beat")
   `NPS_ASSERT_IMPLY(a_rsp_index_range, rsp_valid, rsp_slot_index < nps_pkg::NUM_SLOTS, "slot index out of range")
endmodule
`default_nettype wire

// ===== rtl/core/nps_min_tree.sv =====
// Registered three-level minimum tree that picks the nearest of eight candidates.
`default_nettype none
`include "nearest_palette_slot_defines.svh"
module nps_min_tree (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  nps_pkg::cand_type        in_cand [nps_pkg::MAX_SLOTS],
   output logic                     out_valid,
   output logic [nps_pkg::IDX_W-1:0] out_idx
);
   localparam int L1_N = nps_pkg::MAX_SLOTS / 2;
   localparam int L2_N = L1_N / 2;

   logic              l1_valid_ff, l1_valid_in;
   logic              l2_valid_ff, l2_valid_in;
   logic              out_valid_ff, out_valid_in;
   nps_pkg::cand_type l1_ff [L1_N];
   nps_pkg::cand_type l1_in [L1_N];
   nps_pkg::cand_type l2_ff [L2_N];
   nps_pkg::cand_type l2_in [L2_N];
   nps_pkg::cand_type out_ff, out_in;

   always_comb begin
      l1_valid_in  = in_valid;
      l2_valid_in  = l1_valid_ff;
      out_valid_in = l2_valid_ff;
      for (int i = 0; i < L1_N; i++) begin
         l1_in[i] = nps_pkg::pick_nearer(in_cand[2*i], in_cand[2*i+1]);
      end
      for (int i = 0; i < L2_N; i++) begin
         l2_in[i] = nps_pkg::pick_nearer(l1_ff[2*i], l1_ff[2*i+1]);
      end
      out_in = nps_pkg::pick_nearer(l2_ff[0], l2_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff  <= 1'b0;
         l2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         l1_valid_ff  <= l1_valid_in;
         l2_valid_ff  <= l2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l1_ff  <= l1_in;
      l2_ff  <= l2_in;
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_idx   = out_ff.idx;

   `NPS_ASSERT_IMPLY(a_tree_latency, out_valid_ff, $past(in_valid, 3), "tree output without input beat")
   `NPS_ASSERT_NEXT(a_tree_min, l2_valid_ff, (out_ff.distance <= $past(l2_ff[0].distance)) && (out_ff.distance <= $past(l2_ff[1].distance)), "tree output is not the minimum")
   `NPS_ASSERT_NEXT(a_tree_tie, l2_valid_ff && (l2_ff[0].distance == l2_ff[1].distance), out_ff.idx == $past(l2_ff[0].idx), "tree tie not won by lower slot")
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for nearest_palette_slot: directed and random colors across palette settings.
`default_nettype none
module tb;
   localparam int WARM_GREEN = 238;
   localparam int WARM_BLUE = 197;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PHASES = 12;
   localparam int COLORS_PER_PHASE = 152;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [nps_pkg::CSR_IDX_W-1:0] CSR_UNUSED_FIRST =
      nps_pkg::CSR_IDX_W'(nps_pkg::CSR_NIGHT_MODE + 1);
   localparam logic [nps_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LAST = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   nps_pkg::color_type req_query_color = '0;
   logic rsp_valid;
   logic [nps_pkg::IDX_W-1:0] rsp_slot_index;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [nps_pkg::CSR_IDX_W-1:0] csr_index = '0;
   nps_pkg::word_type csr_wdata = '0;

   nps_pkg::word_type palette_copy [nps_pkg::NUM_WORDS];
   logic night_copy;
   nps_pkg::color_type colors_to_send [$];
   logic [nps_pkg::IDX_W-1:0] expected_slots [$];
   int gap_pct = 16;
   int errors = 0;
   int cycle_count = 0;

   nearest_palette_slot u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_query_color(req_query_color),
      .rsp_valid(rsp_valid),
      .rsp_slot_index(rsp_slot_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Slot color as the comparison sees it, warmed when night mode is on.
   function automatic nps_pkg::color_type slot_as_seen(input int i);
      nps_pkg::color_type s;
      int g;
      int b;
      s = palette_copy[i / 2][(i % 2) * nps_pkg::COLOR_W +: nps_pkg::COLOR_W];
      if (night_copy) begin
         g = s[15:8];
         b = s[7:0];
         g = g * WARM_GREEN / 256;
         b = b * WARM_BLUE / 256;
         s[15:8] = g[7:0];
         s[7:0] = b[7:0];
      end
      return s;
   endfunction

   function automatic logic [nps_pkg::IDX_W-1:0] nearest_slot(input nps_pkg::color_type q);
      nps_pkg::color_type s;
      int dr;
      int dg;
      int db;
      int d;
      int best_d;
      logic [nps_pkg::IDX_W-1:0] best;
      best = '0;
      best_d = 0;
      for (int i = 0; i < nps_pkg::NUM_SLOTS; i++) begin
         s = slot_as_seen(i);
         dr = q[23:16];
         dg = q[15:8];
         db = q[7:0];
         dr -= s[23:16];
         dg -= s[15:8];
         db -= s[7:0];
         d = dr * dr + dg * dg + db * db;
         if (i == 0 || d < best_d) begin
            best_d = d;
            best = i[nps_pkg::IDX_W-1:0];
         end
      end
      return best;
   endfunction

   function automatic nps_pkg::word_type rand_word();
      nps_pkg::word_type w;
      w = nps_pkg::WORD_W'({$urandom, $urandom});
      return w;
   endfunction

   // The caller lowers csr_valid once its last write has gone through.
   task automatic write_csr(input logic [nps_pkg::CSR_IDX_W-1:0] idx,
                            input nps_pkg::word_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx < nps_pkg::CSR_NIGHT_MODE) begin
         palette_copy[idx] = val;
      end else if (idx == nps_pkg::CSR_NIGHT_MODE) begin
         night_copy = val[0];
      end
   endtask

   task automatic set_config(input nps_pkg::word_type words [nps_pkg::NUM_WORDS],
                             input nps_pkg::word_type night_word, input logic stray);
      if (stray) begin
         write_csr(nps_pkg::CSR_IDX_W'($urandom_range(CSR_UNUSED_LAST, CSR_UNUSED_FIRST)),
                   rand_word());
      end
      for (int w = 0; w < nps_pkg::NUM_WORDS; w++) begin
         write_csr(nps_pkg::CSR_IDX_W'(nps_pkg::CSR_PALETTE_0_1 + w), words[w]);
      end
      write_csr(nps_pkg::CSR_NIGHT_MODE, night_word);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (colors_to_send.size() != 0 || start || expected_slots.size() != 0);
   endtask

   always @(posedge clock) begin : drive_blk
      logic fire;
      fire = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (fire) begin
            expected_slots.push_back(nearest_slot(req_query_color));
         end
         if (fire || !start) begin
            if (colors_to_send.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
               start <= 1'b1;
               req_query_color <= colors_to_send.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_blk
      logic [nps_pkg::IDX_W-1:0] want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_slots.size() == 0) begin
            $display("%0t: unexpected slot result, expected none, got %0d",
                     $time, rsp_slot_index);
            errors++;
         end else begin
            want = expected_slots.pop_front();
            if (rsp_slot_index !== want) begin
               $display("%0t: slot index mismatch, expected %0d, got %0d",
                        $time, want, rsp_slot_index);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      nps_pkg::word_type words [nps_pkg::NUM_WORDS];
      nps_pkg::word_type night_word;
      nps_pkg::color_type c;
      int v;
      int r;
      for (int w = 0; w < nps_pkg::NUM_WORDS; w++) begin
         palette_copy[w] = '0;
      end
      night_copy = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // With the cleared palette every slot is equally distant, so slot 0 wins.
      colors_to_send.push_back(24'h000000);
      colors_to_send.push_back(24'hFFFFFF);
      drain();

      // Distinct primaries, with slot 5 a copy of slot 2 so that ties go low.
      words[0] = {24'hFFFFFF, 24'h000000};
      words[1] = {24'h00FF00, 24'hFF0000};
      words[2] = {24'hFF0000, 24'h0000FF};
      words[3] = {24'hFFFF00, 24'h808080};
      set_config(words, 48'hFFFF_FFFF_FFFE, 1'b1);
      for (int i = 0; i < nps_pkg::NUM_SLOTS; i++) begin
         colors_to_send.push_back(slot_as_seen(i));
      end
      colors_to_send.push_back(24'h7F7F7F);
      colors_to_send.push_back(24'h010203);
      drain();

      set_config(words, '1, 1'b0);
      for (int i = 0; i < nps_pkg::NUM_SLOTS; i++) begin
         colors_to_send.push_back(slot_as_seen(i));
      end
      colors_to_send.push_back(24'hFFFFFF);
      colors_to_send.push_back(24'h00FF00);
      drain();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         for (int w = 0; w < nps_pkg::NUM_WORDS; w++) begin
            r = $urandom_range(9, 0);
            if (k == 0) begin
               words[w] = '0;
            end else if (k == 1) begin
               words[w] = '1;
            end else if (r < 2) begin
               c = nps_pkg::COLOR_W'($urandom);
               words[w] = {c, c};
            end else begin
               words[w] = rand_word();
            end
         end
         night_word = rand_word();
         set_config(words, night_word, $urandom_range(2, 0) == 0);
         gap_pct = (k == 4) ? 0 : 16;
         for (int n = 0; n < COLORS_PER_PHASE; n++) begin
            r = $urandom_range(99, 0);
            if (r < 45) begin
               c = nps_pkg::COLOR_W'($urandom);
            end else if (r < 85) begin
               c = slot_as_seen($urandom_range(nps_pkg::NUM_SLOTS - 1, 0));
               for (int ch = 0; ch < nps_pkg::NUM_CH; ch++) begin
                  v = c[ch * nps_pkg::CH_W +: nps_pkg::CH_W];
                  v = v + int'($urandom_range(6, 0)) - 3;
                  v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                  c[ch * nps_pkg::CH_W +: nps_pkg::CH_W] = v[nps_pkg::CH_W-1:0];
               end
            end else if (r < 93) begin
               c = slot_as_seen($urandom_range(nps_pkg::NUM_SLOTS - 1, 0));
            end else begin
               for (int ch = 0; ch < nps_pkg::NUM_CH; ch++) begin
                  c[ch * nps_pkg::CH_W +: nps_pkg::CH_W] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
               end
            end
            colors_to_send.push_back(c);
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_slots.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
